### rtl/core/pdbhc_pkg.sv
package pdbhc_pkg;

    // Field widths
    localparam int ANGLE_WIDTH = 16;
    localparam int DRIVE_WIDTH = 16;
    localparam int GAIN_W      = 16;
    localparam int INV_W       = 10;
    localparam int BAND_W      = 15;
    localparam int LIM_W       = 15;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // Fixed-point: Q.20 products back to Q8.8 drop the angle fraction bits
    localparam int ANGLE_FRAC  = 12;

    // Datapath widths
    localparam int DIFF_W  = ANGLE_WIDTH + 1;
    localparam int RATE_W  = DIFF_W + INV_W;
    localparam int MA_W    = (DIFF_W > GAIN_W + 1) ? DIFF_W : GAIN_W + 1;
    localparam int MB_W    = (RATE_W > ANGLE_WIDTH) ? RATE_W : ANGLE_WIDTH;
    localparam int PROD_W  = MA_W + MB_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int MAG_W   = ANGLE_WIDTH + 1;
    localparam int CMP_W   = (MAG_W > BAND_W) ? MAG_W : BAND_W;

    localparam logic signed [ACC_W-1:0] DRIVE_MAX =
        ACC_W'((64'd1 << (DRIVE_WIDTH - 1)) - 64'd1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_PERIOD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_BAND   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT = 3'd4;

    // Register reset values
    localparam logic [GAIN_W-1:0] RST_GAIN_P      = 16'd11520;
    localparam logic [GAIN_W-1:0] RST_GAIN_D      = 16'd1024;
    localparam logic [INV_W-1:0]  RST_INV_PERIOD  = 10'd100;
    localparam logic [BAND_W-1:0] RST_NEAR_BAND   = 15'd205;
    localparam logic [LIM_W-1:0]  RST_DRIVE_LIMIT = 15'd5120;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_d;
        logic [INV_W-1:0]  inv_period;
        logic [BAND_W-1:0] near_band;
        logic [LIM_W-1:0]  drive_limit;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic load;     // capture angle, form rate
        logic p_step;   // acc = gain_p * angle
        logic d_step;   // acc += gain_d * rate
        logic out_load; // shift, clamp, fill output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

### rtl/core/pd_controller_band_halving_clamp_core.sv
// Channel   | Handshake           | Payload
// ----------+---------------------+-----------------------------------------
// request   | i_valid / o_ready   | i_angle   (signed Q3.12)
// result    | o_valid / i_ready   | o_drive   (signed Q8.8), o_clamped
// config    | i_cfg_we            | i_cfg_idx, i_cfg_data (write only)
//
// A request runs in four steps: the accept cycle forms the rate on the shared
// multiplier, the P and D steps form the P and D products on that same
// multiplier, and the finish step shifts, clamps and loads the output register.
// Reset is synchronous and active low; it restores the register defaults and
// clears the previous angle and the output valid.
// A stalled result holds the block in its last step; the next request is
// taken once the result is loaded and the controller is back at idle.
module pd_controller_band_halving_clamp_core
    import pdbhc_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [ANGLE_WIDTH-1:0] i_angle,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [DRIVE_WIDTH-1:0] o_drive,
    output logic                          o_clamped,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data
);

    t_cfg    w_cfg;
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Configuration registers
    pdbhc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // Sequencer: idle, P product, D product, finish
    pdbhc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // Rate, products, accumulate, halve, clamp, output register
    pdbhc_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .i_angle   (i_angle),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_drive   (o_drive),
        .o_clamped (o_clamped)
    );

    // Effective limit as seen at the drive width, for checking only
    logic signed [DRIVE_WIDTH:0] w_chk_lim;
    assign w_chk_lim = (ACC_W'({1'b0, w_cfg.drive_limit}) > DRIVE_MAX) ?
                       (DRIVE_WIDTH + 1)'(DRIVE_MAX) :
                       (DRIVE_WIDTH + 1)'({1'b0, w_cfg.drive_limit});

    // An accepted request keeps the block busy through its three work steps
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready ##1 !o_ready ##1 !o_ready)
        else $error("request accepted while previous one still in work");

    // A flagged result sits exactly on the limit
    a_clamp_on_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_clamped |->
            ((DRIVE_WIDTH + 1)'(o_drive) == w_chk_lim) ||
            ((DRIVE_WIDTH + 1)'(o_drive) == -w_chk_lim))
        else $error("clamped drive not at limit");

    // No datapath command other than load while idle
    a_idle_no_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !w_cmd.p_step && !w_cmd.d_step && !w_cmd.out_load)
        else $error("datapath step issued while idle");

endmodule

### rtl/core/pdbhc_cfg.sv
module pdbhc_cfg
    import pdbhc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p      <= RST_GAIN_P;
            r_cfg.gain_d      <= RST_GAIN_D;
            r_cfg.inv_period  <= RST_INV_PERIOD;
            r_cfg.near_band   <= RST_NEAR_BAND;
            r_cfg.drive_limit <= RST_DRIVE_LIMIT;
        end else if (i_cfg_we) begin
            // keep only each register's width; drop unknown indexes
            unique case (i_cfg_idx)
                REG_GAIN_P:      r_cfg.gain_p      <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_D:      r_cfg.gain_d      <= i_cfg_data[GAIN_W-1:0];
                REG_INV_PERIOD:  r_cfg.inv_period  <= i_cfg_data[INV_W-1:0];
                REG_NEAR_BAND:   r_cfg.near_band   <= i_cfg_data[BAND_W-1:0];
                REG_DRIVE_LIMIT: r_cfg.drive_limit <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/core/pdbhc_ctrl.sv
module pdbhc_ctrl
    import pdbhc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_P    = 4'b0010,
        S_D    = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_P;
                end
            end
            S_P: begin
                o_cmd.p_step = 1'b1;
                n_state      = S_D;
            end
            S_D: begin
                o_cmd.d_step = 1'b1;
                n_state      = S_FIN;
            end
            S_FIN: begin
                // hold until the output register can take the result
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

### rtl/core/pdbhc_dp.sv
module pdbhc_dp
    import pdbhc_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cfg                          i_cfg,
    input  t_dp_cmd                       i_cmd,
    output t_dp_sts                       o_sts,
    input  logic signed [ANGLE_WIDTH-1:0] i_angle,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [DRIVE_WIDTH-1:0] o_drive,
    output logic                          o_clamped
);

    logic signed [ANGLE_WIDTH-1:0] r_last_angle;
    logic signed [ANGLE_WIDTH-1:0] r_angle;
    logic signed [RATE_W-1:0]      r_rate;
    logic signed [ACC_W-1:0]       r_acc;
    logic signed [DRIVE_WIDTH-1:0] r_drive;
    logic                          r_clamped;
    logic                          r_out_valid;

    logic signed [DIFF_W-1:0]  w_diff;
    logic signed [MA_W-1:0]    w_a;
    logic signed [MB_W-1:0]    w_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [ACC_W-1:0]   w_neg;
    logic signed [ACC_W-1:0]   w_shift;
    logic signed [ACC_W-1:0]   w_lim;
    logic signed [ACC_W-1:0]   w_lim_ext;
    logic signed [ACC_W-1:0]   w_res;
    logic signed [MAG_W-1:0]   w_ang_x;
    logic [MAG_W-1:0]          w_mag;
    logic                      w_half;
    logic                      w_clamp;

    assign w_diff = DIFF_W'(i_angle) - DIFF_W'(r_last_angle);

    // shared multiplier
    always_comb begin
        priority if (i_cmd.load) begin
            w_a = MA_W'(w_diff);
            w_b = MB_W'({1'b0, i_cfg.inv_period});
        end else if (i_cmd.p_step) begin
            w_a = MA_W'({1'b0, i_cfg.gain_p});
            w_b = MB_W'(r_angle);
        end else begin
            w_a = MA_W'({1'b0, i_cfg.gain_d});
            w_b = MB_W'(r_rate);
        end
    end

    assign w_prod = w_a * w_b;

    // band test on |angle|
    assign w_ang_x = MAG_W'(r_angle);
    assign w_mag   = w_ang_x[MAG_W-1] ? MAG_W'(-w_ang_x) : w_ang_x;
    assign w_half  = CMP_W'(w_mag) < CMP_W'(i_cfg.near_band);

    // negate, floor shift, clamp
    assign w_neg     = -r_acc;
    assign w_shift   = w_half ? (w_neg >>> (ANGLE_FRAC + 1)) : (w_neg >>> ANGLE_FRAC);
    assign w_lim_ext = ACC_W'({1'b0, i_cfg.drive_limit});
    assign w_lim     = (w_lim_ext > DRIVE_MAX) ? DRIVE_MAX : w_lim_ext;

    always_comb begin
        w_res   = w_shift;
        w_clamp = 1'b0;
        if (w_shift > w_lim) begin
            w_res   = w_lim;
            w_clamp = 1'b1;
        end else if (w_shift < -w_lim) begin
            w_res   = -w_lim;
            w_clamp = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_angle <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_last_angle <= i_angle;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_angle <= i_angle;
            r_rate  <= RATE_W'(w_prod);
        end
        if (i_cmd.p_step) begin
            r_acc <= ACC_W'(w_prod);
        end else if (i_cmd.d_step) begin
            r_acc <= r_acc + ACC_W'(w_prod);
        end
        if (i_cmd.out_load) begin
            r_drive   <= DRIVE_WIDTH'(w_res);
            r_clamped <= w_clamp;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_ready;
    assign o_valid        = r_out_valid;
    assign o_drive        = r_drive;
    assign o_clamped      = r_clamped;

endmodule

### verif/testbench.sv
// Self-checking bench for the PD tilt controller core.
//
// Each request carries one Q3.12 angle and returns one Q8.8 drive with a
// clamp flag. A local model of the datapath (rate from the previous angle,
// P and D products at full width, floor shift by 12 or 13 near the band,
// symmetric clamp) predicts every result when the request is accepted. The
// scoreboard then compares each accepted result against the oldest entry.
//
// Stimulus runs in two parts. A directed plan covers reset defaults, field
// extremes, the band edge, zero rate, clamp edges and register masking.
// Random phases follow, each with its own register setting, with idle and
// stall on both channels. One phase runs with no idling at all. One phase
// holds the result channel off long enough to back the block up.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pdbhc_pkg::*;

    // Indexes past the register list; writes to them must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam int    WATCHDOG_LIMIT = 3000;
    localparam int    HOLDOFF_CYCLES = 400;
    localparam int    PHASE_COUNT    = 7;
    localparam int    PHASE_ITEMS    = 200;
    localparam int    NO_IDLE_PHASE  = 3;
    localparam int    HOLDOFF_PHASE  = 5;
    localparam longint DRIVE_TOP     = (64'sd1 <<< (DRIVE_WIDTH - 1)) - 64'sd1;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} t_row_kind;

    // One line of the directed plan: a register write or a request, with
    // a typed-in result where it is obvious from the arithmetic
    typedef struct packed {
        t_row_kind                      kind;
        logic [CFG_IDX_W-1:0]           idx;
        logic [CFG_DATA_W-1:0]          data;
        logic signed [ANGLE_WIDTH-1:0]  angle;
        logic                           pinned;
        logic signed [DRIVE_WIDTH-1:0]  drive;
        logic                           clamped;
    } t_step_row;

    typedef struct packed {
        logic signed [DRIVE_WIDTH-1:0] drive;
        logic                          clamped;
    } t_drive_word;

    localparam int PLAN_LEN = 35;

    // Opening rows run on the reset defaults: gain_p 45.0, gain_d 4.0,
    // inv_period 100, near_band 205, limit 20.0
    localparam t_step_row DIRECTED_PLAN [PLAN_LEN] = '{
        '{ROW_SAMPLE, REG_GAIN_P,      16'h0000, 16'sd0,     1'b1, 16'sd0,      1'b0},
        '{ROW_SAMPLE, REG_GAIN_P,      16'h0000, 16'sd32767, 1'b1, -16'sd5120,  1'b1},
        '{ROW_SAMPLE, REG_GAIN_P,      16'h0000, 16'sh8000,  1'b1, 16'sd5120,   1'b1},
        '{ROW_SAMPLE, REG_GAIN_P,      16'h0000, 16'sd204,   1'b0, 16'sd0,      1'b0},
        '{ROW_SAMPLE, REG_GAIN_P,      16'h0000, 16'sd205,   1'b0, 16'sd0,      1'b0},
        '{ROW_SAMPLE, REG_GAIN_P,      16'h0000, -16'sd204,  1'b0, 16'sd0,      1'b0},
        '{ROW_SAMPLE, REG_GAIN_P,      16'h0000, -16'sd205,  1'b0, 16'sd0,      1'b0},
        // zero inverse period: only the P term is left
        '{ROW_WRITE,  REG_INV_PERIOD,  16'h0000, 16'sd0,     1'b0, 16'sd0,      1'b0},
        '{ROW_SAMPLE, REG_GAIN_P,      16'h0000, 16'sd1000,  1'b0, 16'sd0,      1'b0},
        '{ROW_SAMPLE, REG_GAIN_P,      16'h0000, -16'sd1000, 1'b0, 16'sd0,      1'b0},
        // unity P gain, no D, no band: drive is the negated angle
        '{ROW_WRITE,  REG_GAIN_P,      16'd4096, 16'sd0,     1'b0, 16'sd0,      1'b0},
        '{ROW_WRITE,  REG_GAIN_D,      16'h0000, 16'sd0,     1'b0, 16'sd0,      1'b0},
        '{ROW_WRITE,  REG_NEAR_BAND,   16'h0000, 16'sd0,     1'b0, 16'sd0,      1'b0},
        '{ROW_WRITE,  REG_DRIVE_LIMIT, 16'd100,  16'sd0,     1'b0, 16'sd0,      1'b0},
        '{ROW_SAMPLE, REG_GAIN_P,      16'h0000, -16'sd100,  1'b1, 16'sd100,    1'b0},
        '{ROW_SAMPLE, REG_GAIN_P,      16'h0000, -16'sd101,  1'b1, 16'sd100,    1'b1},
        '{ROW_SAMPLE, REG_GAIN_P,      16'h0000, 16'sd100,   1'b1, -16'sd100,   1'b0},
        '{ROW_SAMPLE, REG_GAIN_P,      16'h0000, 16'sd101,   1'b1, -16'sd100,   1'b1},
        '{ROW_SAMPLE, REG_GAIN_P,      16'h0000, 16'sd0,     1'b1, 16'sd0,      1'b0},
        // zero limit: any nonzero drive is cut and flagged
        '{ROW_WRITE,  REG_DRIVE_LIMIT, 16'h0000, 16'sd0,     1'b0, 16'sd0,      1'b0},
        '{ROW_SAMPLE, REG_GAIN_P,      16'h0000, 16'sd1,     1'b1, 16'sd0,      1'b1},
        '{ROW_SAMPLE, REG_GAIN_P,      16'h0000, 16'sd0,     1'b1, 16'sd0,      1'b0},
        // all-ones write keeps 15 bits: limit reaches the top of the drive range
        '{ROW_WRITE,  REG_DRIVE_LIMIT, 16'hFFFF, 16'sd0,     1'b0, 16'sd0,      1'b0},
        '{ROW_SAMPLE, REG_GAIN_P,      16'h0000, 16'sd32767, 1'b1, -16'sd32767, 1'b0},
        '{ROW_SAMPLE, REG_GAIN_P,      16'h0000, 16'sh8000,  1'b1, 16'sd32767,  1'b1},
        // every register at its widest, then writes past the list
        '{ROW_WRITE,  REG_GAIN_P,      16'hFFFF, 16'sd0,     1'b0, 16'sd0,      1'b0},
        '{ROW_WRITE,  REG_GAIN_D,      16'hFFFF, 16'sd0,     1'b0, 16'sd0,      1'b0},
        '{ROW_WRITE,  REG_INV_PERIOD,  16'hFFFF, 16'sd0,     1'b0, 16'sd0,      1'b0},
        '{ROW_WRITE,  REG_NEAR_BAND,   16'hFFFF, 16'sd0,     1'b0, 16'sd0,      1'b0},
        '{ROW_WRITE,  REG_SPARE_LO,    16'h0000, 16'sd0,     1'b0, 16'sd0,      1'b0},
        '{ROW_WRITE,  REG_SPARE_HI,    16'h0000, 16'sd0,     1'b0, 16'sd0,      1'b0},
        '{ROW_SAMPLE, REG_GAIN_P,      16'h0000, 16'sd32767, 1'b0, 16'sd0,      1'b0},
        '{ROW_SAMPLE, REG_GAIN_P,      16'h0000, 16'sh8000,  1'b0, 16'sd0,      1'b0},
        '{ROW_SAMPLE, REG_GAIN_P,      16'h0000, 16'sd0,     1'b0, 16'sd0,      1'b0},
        '{ROW_SAMPLE, REG_GAIN_P,      16'h0000, 16'sd123,   1'b0, 16'sd0,      1'b0}
    };

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_ready;
    logic signed [ANGLE_WIDTH-1:0] i_angle;
    logic                          o_valid;
    logic                          i_ready;
    logic signed [DRIVE_WIDTH-1:0] o_drive;
    logic                          o_clamped;
    logic                          i_cfg_we;
    logic [CFG_IDX_W-1:0]          i_cfg_idx;
    logic [CFG_DATA_W-1:0]         i_cfg_data;

    // Typed-in result travels with the request payload, so it stays put
    // until the request is accepted
    logic                          pin_on;
    logic signed [DRIVE_WIDTH-1:0] pin_drive;
    logic                          pin_clamped;

    // Local copy of the block's registers and angle memory
    t_cfg                          cfg_model;
    logic signed [ANGLE_WIDTH-1:0] prev_angle_model;

    t_drive_word                   expected_drives[$];
    logic signed [ANGLE_WIDTH-1:0] last_sent;
    int                            errors;
    int                            stall_cycles;
    int                            hold_cycles;
    bit                            tx_idle_on;
    bit                            rx_idle_on;

    pd_controller_band_halving_clamp_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_angle    (i_angle),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_drive    (o_drive),
        .o_clamped  (o_clamped),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Drive for one angle given the current registers and previous angle.
    // All products stay in 64-bit signed, far from overflow at these widths.
    function automatic void calc_drive(input logic signed [ANGLE_WIDTH-1:0] angle,
                                       output logic signed [DRIVE_WIDTH-1:0] drive,
                                       output logic clamped);
        longint rate;
        longint p_prod;
        longint d_prod;
        longint neg_sum;
        longint mag;
        longint lim;
        longint value;
        int     shamt;
        rate    = (longint'(angle) - longint'(prev_angle_model))
                  * longint'(cfg_model.inv_period);
        p_prod  = longint'(cfg_model.gain_p) * longint'(angle);
        d_prod  = longint'(cfg_model.gain_d) * rate;
        neg_sum = -(p_prod + d_prod);
        mag     = (angle < 0) ? -longint'(angle) : longint'(angle);
        // Strict compare: a zero band never halves
        shamt   = (mag < longint'(cfg_model.near_band)) ? ANGLE_FRAC + 1 : ANGLE_FRAC;
        // Arithmetic shift of a signed value floors toward minus infinity
        value   = neg_sum >>> shamt;
        lim     = longint'(cfg_model.drive_limit);
        if (lim > DRIVE_TOP)
            lim = DRIVE_TOP;
        clamped = 1'b0;
        if (value > lim) begin
            value   = lim;
            clamped = 1'b1;
        end else if (value < -lim) begin
            value   = -lim;
            clamped = 1'b1;
        end
        drive = value[DRIVE_WIDTH-1:0];
    endfunction

    // Mix of angles: the largest share near the band so halving and unclamped drives
    // show up, some as small steps from the last angle, the rest anywhere
    // in range or at the edges
    function automatic logic signed [ANGLE_WIDTH-1:0] pick_angle();
        int sel;
        int span;
        int v;
        sel = $urandom_range(99);
        if (sel < 35) begin
            span = int'(cfg_model.near_band) * 2 + 64;
            if (span > 32767)
                span = 32767;
            v = int'($urandom_range(2 * span)) - span;
        end else if (sel < 55) begin
            v = int'(last_sent) + int'($urandom_range(400)) - 200;
        end else if (sel < 88) begin
            v = int'($urandom_range(65535)) - 32768;
        end else begin
            case ($urandom_range(5))
                0: v = 32767;
                1: v = -32768;
                2: v = 0;
                3: v = int'(cfg_model.near_band);
                4: v = -int'(cfg_model.near_band);
                default: v = int'(cfg_model.near_band) - 1;
            endcase
        end
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[ANGLE_WIDTH-1:0];
    endfunction

    // Write one register on the port and in the local copy; the enable is
    // left high so back-to-back writes need no gap between them
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_GAIN_P:      cfg_model.gain_p      = data[GAIN_W-1:0];
            REG_GAIN_D:      cfg_model.gain_d      = data[GAIN_W-1:0];
            REG_INV_PERIOD:  cfg_model.inv_period  = data[INV_W-1:0];
            REG_NEAR_BAND:   cfg_model.near_band   = data[BAND_W-1:0];
            REG_DRIVE_LIMIT: cfg_model.drive_limit = data[LIM_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Offer one request and hold it until accepted. Valid stays high from
    // one request into the next unless a gap is drawn.
    task automatic send_angle(input logic signed [ANGLE_WIDTH-1:0] angle,
                              input logic pinned,
                              input logic signed [DRIVE_WIDTH-1:0] drive,
                              input logic clamped);
        i_cfg_we <= 1'b0;
        if (tx_idle_on && $urandom_range(99) < 36) begin
            i_valid <= 1'b0;
            do
                @(posedge i_clk);
            while ($urandom_range(99) < 36);
        end
        i_valid     <= 1'b1;
        i_angle     <= angle;
        pin_on      <= pinned;
        pin_drive   <= drive;
        pin_clamped <= clamped;
        last_sent    = angle;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
    endtask

    // Drop valid and the write enable, then wait until every result is back
    task automatic drain();
        i_valid  <= 1'b0;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        while (expected_drives.size() != 0)
            @(posedge i_clk);
    endtask

    // Register setting for one random phase: defaults, all ones, minimums with
    // inv_period at one, then random values with gains small half the time
    task automatic set_phase(input int ph);
        case (ph)
            0: begin
                cfg_write(REG_GAIN_P,      CFG_DATA_W'(RST_GAIN_P));
                cfg_write(REG_GAIN_D,      CFG_DATA_W'(RST_GAIN_D));
                cfg_write(REG_INV_PERIOD,  CFG_DATA_W'(RST_INV_PERIOD));
                cfg_write(REG_NEAR_BAND,   CFG_DATA_W'(RST_NEAR_BAND));
                cfg_write(REG_DRIVE_LIMIT, CFG_DATA_W'(RST_DRIVE_LIMIT));
            end
            1: begin
                cfg_write(REG_GAIN_P,      16'hFFFF);
                cfg_write(REG_GAIN_D,      16'hFFFF);
                cfg_write(REG_INV_PERIOD,  16'hFFFF);
                cfg_write(REG_NEAR_BAND,   16'hFFFF);
                cfg_write(REG_DRIVE_LIMIT, 16'hFFFF);
            end
            2: begin
                cfg_write(REG_GAIN_P,      16'h0000);
                cfg_write(REG_GAIN_D,      16'h0000);
                cfg_write(REG_INV_PERIOD,  16'h0001);
                cfg_write(REG_NEAR_BAND,   16'h0000);
                cfg_write(REG_DRIVE_LIMIT, 16'h0000);
            end
            default: begin
                cfg_write(REG_GAIN_P,
                          CFG_DATA_W'($urandom_range(1) ? $urandom_range(2047)
                                                        : $urandom_range(65535)));
                cfg_write(REG_GAIN_D,
                          CFG_DATA_W'($urandom_range(1) ? $urandom_range(511)
                                                        : $urandom_range(65535)));
                cfg_write(REG_INV_PERIOD, CFG_DATA_W'($urandom_range(65535)));
                cfg_write(REG_NEAR_BAND,
                          CFG_DATA_W'($urandom_range(1) ? $urandom_range(4095)
                                                        : $urandom_range(65535)));
                cfg_write(REG_DRIVE_LIMIT, CFG_DATA_W'($urandom_range(65535)));
            end
        endcase
    endtask

    // Result side: random stalls, a clean stretch, and one long hold-off
    // counted down here while the sender keeps offering requests
    initial begin : result_sink
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                i_ready     <= 1'b0;
                hold_cycles  = hold_cycles - 1;
            end else if (!rx_idle_on) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(99) >= 36);
            end
        end
    end

    // Predict on every accepted request, check every accepted result, and
    // stop the run if nothing moves on either channel for too long
    always @(posedge i_clk) begin : scoreboard
        t_drive_word                   want;
        logic signed [DRIVE_WIDTH-1:0] drive;
        logic                          clamped;
        bit                            moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                calc_drive(i_angle, drive, clamped);
                want.drive   = pin_on ? pin_drive : drive;
                want.clamped = pin_on ? pin_clamped : clamped;
                expected_drives.push_back(want);
                prev_angle_model = i_angle;
                moved            = 1'b1;
            end
            if (o_valid && i_ready) begin
                moved = 1'b1;
                if (expected_drives.size() == 0) begin
                    $display("%0t: result with no request pending: drive %0d clamped %0b",
                             $time, o_drive, o_clamped);
                    errors = errors + 1;
                end else begin
                    want = expected_drives.pop_front();
                    if (o_drive !== want.drive) begin
                        $display("%0t: drive mismatch: expected %0d actual %0d",
                                 $time, want.drive, o_drive);
                        errors = errors + 1;
                    end
                    if (o_clamped !== want.clamped) begin
                        $display("%0t: clamped mismatch: expected %0b actual %0b",
                                 $time, want.clamped, o_clamped);
                        errors = errors + 1;
                    end
                end
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: timeout, %0d results still pending",
                         $time, expected_drives.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int  ph;
        int  n;
        bit  prev_write;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_angle     <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= '0;
        i_cfg_data  <= '0;
        pin_on      <= 1'b0;
        pin_drive   <= '0;
        pin_clamped <= 1'b0;
        errors       = 0;
        stall_cycles = 0;
        hold_cycles  = 0;
        tx_idle_on   = 1'b1;
        rx_idle_on   = 1'b1;
        last_sent    = '0;
        prev_write   = 1'b1;

        // Reset state of the model: register defaults, angle memory cleared
        cfg_model.gain_p      = RST_GAIN_P;
        cfg_model.gain_d      = RST_GAIN_D;
        cfg_model.inv_period  = RST_INV_PERIOD;
        cfg_model.near_band   = RST_NEAR_BAND;
        cfg_model.drive_limit = RST_DRIVE_LIMIT;
        prev_angle_model      = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed plan; drain before a write that follows requests
        foreach (DIRECTED_PLAN[k]) begin
            if (DIRECTED_PLAN[k].kind == ROW_WRITE) begin
                if (!prev_write)
                    drain();
                cfg_write(DIRECTED_PLAN[k].idx, DIRECTED_PLAN[k].data);
                prev_write = 1'b1;
            end else begin
                send_angle(DIRECTED_PLAN[k].angle, DIRECTED_PLAN[k].pinned,
                           DIRECTED_PLAN[k].drive, DIRECTED_PLAN[k].clamped);
                prev_write = 1'b0;
            end
        end

        // Random phases, each on an idle block with fresh registers
        for (ph = 0; ph < PHASE_COUNT; ph++) begin
            drain();
            set_phase(ph);
            tx_idle_on = (ph != NO_IDLE_PHASE);
            rx_idle_on = (ph != NO_IDLE_PHASE);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == HOLDOFF_PHASE && n == 40)
                    hold_cycles = HOLDOFF_CYCLES;
                send_angle(pick_angle(), 1'b0, '0, 1'b0);
            end
        end

        // Let the last results out, then wait for anything stray
        drain();
        repeat (8) @(posedge i_clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### sim.f
rtl/core/pdbhc_pkg.sv
rtl/core/pdbhc_cfg.sv
rtl/core/pdbhc_ctrl.sv
rtl/core/pdbhc_dp.sv
rtl/core/pd_controller_band_halving_clamp_core.sv
verif/testbench.sv
